FILE: sv/lcm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcm_pkg
// Shared constants and state types for the least common multiple block.
// ----------------------------------------------------------------------------
package lcm_pkg;

    localparam int OPERAND_WIDTH_DEF = 32;  // default operand width
    localparam int FIELD_WIDTH       = 32;  // operand and divisor field width
    localparam int MULT_WIDTH        = 64;  // multiple field width

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GCD,
        ST_DIV,
        ST_MUL,
        ST_OUT
    } lcm_state_t;

    typedef enum logic [2:0] {
        G_IDLE,
        G_EVEN,
        G_REDUCE,
        G_SCALE,
        G_DONE
    } gcd_state_t;

endpackage

FILE: sv/least_common_multiple_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// least_common_multiple_top
// Least common multiple and greatest common divisor of two unsigned operands.
// Zero operand: accepted in idle, then the zero result goes through the output
//   register to m_axis_tvalid. Otherwise binary GCD (W = OPERAND_WIDTH), then W
//   restoring divide steps and W shift-add multiply steps, then the output register.
// Flow: one item at a time; a new pair is taken only while the sequencer is idle.
// Reset: aresetn synchronous, active low; clears the sequencer and output valid.
// ----------------------------------------------------------------------------
module least_common_multiple_top #(
    parameter int OPERAND_WIDTH = lcm_pkg::OPERAND_WIDTH_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    // input items
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [63:0]  s_axis_tdata,   // [31:0] operand_a, [63:32] operand_b
    // result items
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [95:0]  m_axis_tdata,   // [63:0] multiple, [95:64] divisor
    output logic         m_axis_tuser    // [0] zero_operand
);
    import lcm_pkg::*;

    localparam int W  = OPERAND_WIDTH;
    localparam int CW = $clog2(W);

    lcm_state_t state_reg, state_next;

    // operands, masked to W bits
    logic [W-1:0] a_in, b_in;
    logic         in_zero;
    logic         s_accept;

    // datapath registers
    logic [W-1:0]   q_reg, q_next;     // dividend in, quotient out
    logic [W:0]     r_reg, r_next;     // partial remainder
    logic [W-1:0]   b_reg, b_next;     // multiplicand
    logic [W-1:0]   g_reg, g_next;     // divisor from the GCD unit
    logic [2*W-1:0] p_reg, p_next;     // product, multiplier in low half
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic           zero_reg, zero_next;

    // output register
    logic [MULT_WIDTH-1:0]  mult_out_reg, mult_out_next;
    logic [FIELD_WIDTH-1:0] div_out_reg, div_out_next;
    logic                   zflag_out_reg, zflag_out_next;
    logic                   m_valid_reg, m_valid_next;
    logic                   out_load;

    // GCD unit
    logic         gcd_start, gcd_done;
    logic [W-1:0] gcd_val;

    // one divide step and one multiply step
    logic [W:0]   div_shift;
    logic         div_ge;
    logic [W-1:0] q_step;
    logic [W:0]   mul_sum;

    assign a_in     = s_axis_tdata[W-1:0];
    assign b_in     = s_axis_tdata[FIELD_WIDTH +: W];
    assign in_zero  = (a_in == '0) || (b_in == '0);
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_accept = s_axis_tvalid && s_axis_tready;
    assign gcd_start = s_accept && !in_zero;

    lcm_gcd #(
        .OPERAND_WIDTH (OPERAND_WIDTH)
    ) u_gcd (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (gcd_start),
        .in_a    (a_in),
        .in_b    (b_in),
        .done    (gcd_done),
        .gcd     (gcd_val)
    );

    // restoring division: shift in one dividend bit, subtract if it fits
    assign div_shift = {r_reg[W-1:0], q_reg[W-1]};
    assign div_ge    = (div_shift >= {1'b0, g_reg});
    assign q_step    = {q_reg[W-2:0], div_ge};

    // shift-add multiply: add b to the upper half when the low bit is set
    assign mul_sum = {1'b0, p_reg[2*W-1:W]} + (p_reg[0] ? {1'b0, b_reg} : '0);

    // output register frees up when empty or being taken
    assign out_load = (state_reg == ST_OUT) && (!m_valid_reg || m_axis_tready);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) state_next = in_zero ? ST_OUT : ST_GCD;
            end
            ST_GCD: begin
                if (gcd_done) state_next = ST_DIV;
            end
            ST_DIV: begin
                if (cnt_reg == '0) state_next = ST_MUL;
            end
            ST_MUL: begin
                if (cnt_reg == '0) state_next = ST_OUT;
            end
            ST_OUT: begin
                if (out_load) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath
    always_comb begin
        q_next    = q_reg;
        r_next    = r_reg;
        b_next    = b_reg;
        g_next    = g_reg;
        p_next    = p_reg;
        cnt_next  = cnt_reg;
        zero_next = zero_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    q_next    = a_in;
                    b_next    = b_in;
                    zero_next = in_zero;
                end
            end
            ST_GCD: begin
                if (gcd_done) begin
                    g_next   = gcd_val;
                    r_next   = '0;
                    cnt_next = CW'(W - 1);
                end
            end
            ST_DIV: begin
                q_next   = q_step;
                r_next   = div_ge ? (div_shift - {1'b0, g_reg}) : div_shift;
                cnt_next = cnt_reg - CW'(1);
                if (cnt_reg == '0) begin
                    p_next   = {{W{1'b0}}, q_step};
                    cnt_next = CW'(W - 1);
                end
            end
            ST_MUL: begin
                p_next   = {mul_sum, p_reg[W-1:1]};
                cnt_next = cnt_reg - CW'(1);
            end
            ST_OUT: begin
                q_next = q_reg;
            end
            default: begin
                q_next = q_reg;
            end
        endcase
    end

    // output register
    always_comb begin
        mult_out_next  = mult_out_reg;
        div_out_next   = div_out_reg;
        zflag_out_next = zflag_out_reg;
        m_valid_next   = m_valid_reg;
        if (m_valid_reg && m_axis_tready) m_valid_next = 1'b0;
        if (out_load) begin
            mult_out_next  = zero_reg ? '0 : MULT_WIDTH'(p_reg);
            div_out_next   = zero_reg ? '0 : FIELD_WIDTH'(g_reg);
            zflag_out_next = zero_reg;
            m_valid_next   = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        q_reg         <= q_next;
        r_reg         <= r_next;
        b_reg         <= b_next;
        g_reg         <= g_next;
        p_reg         <= p_next;
        cnt_reg       <= cnt_next;
        zero_reg      <= zero_next;
        mult_out_reg  <= mult_out_next;
        div_out_reg   <= div_out_next;
        zflag_out_reg <= zflag_out_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {div_out_reg, mult_out_reg};
    assign m_axis_tuser  = zflag_out_reg;

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------

    // zero operand gives zero results
    a_zero_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("zero operand item carries nonzero results");

    // normal results are never zero
    a_nonzero_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tuser) |->
            (m_axis_tdata[63:0] != '0) && (m_axis_tdata[95:64] != '0))
        else $error("nonzero operands gave a zero result");

    // GCD unit finishes only while the sequencer waits for it
    a_gcd_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        gcd_done |-> (state_reg == ST_GCD))
        else $error("GCD done outside the GCD phase");

    // the division leaves a remainder below the divisor
    a_div_remainder: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV && cnt_reg == '0) |=> (r_reg < {1'b0, g_reg}))
        else $error("division remainder not below divisor");

endmodule

FILE: sv/lcm_gcd.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcm_gcd
// Binary GCD unit: strip the common power of two, then one shift or subtract
// per cycle, then rescale by that common power of two one bit per cycle.
// ----------------------------------------------------------------------------
module lcm_gcd #(
    parameter int OPERAND_WIDTH = lcm_pkg::OPERAND_WIDTH_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic [OPERAND_WIDTH-1:0] in_a,   // nonzero
    input  logic [OPERAND_WIDTH-1:0] in_b,   // nonzero
    output logic                     done,
    output logic [OPERAND_WIDTH-1:0] gcd
);
    import lcm_pkg::*;

    localparam int CW = $clog2(OPERAND_WIDTH);

    gcd_state_t state_reg, state_next;
    logic [OPERAND_WIDTH-1:0] u_reg, u_next;
    logic [OPERAND_WIDTH-1:0] v_reg, v_next;
    logic [CW-1:0]            k_reg, k_next;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            G_IDLE: begin
                if (start) state_next = G_EVEN;
            end
            G_EVEN: begin
                if (u_reg[0] || v_reg[0]) state_next = G_REDUCE;
            end
            G_REDUCE: begin
                if (u_reg == v_reg) state_next = (k_reg == '0) ? G_DONE : G_SCALE;
            end
            G_SCALE: begin
                if (k_reg == CW'(1)) state_next = G_DONE;
            end
            G_DONE: state_next = G_IDLE;
            default: state_next = G_IDLE;
        endcase
    end

    // datapath
    always_comb begin
        u_next = u_reg;
        v_next = v_reg;
        k_next = k_reg;
        unique case (state_reg)
            G_IDLE: begin
                if (start) begin
                    u_next = in_a;
                    v_next = in_b;
                    k_next = '0;
                end
            end
            G_EVEN: begin
                if (!u_reg[0] && !v_reg[0]) begin
                    u_next = u_reg >> 1;
                    v_next = v_reg >> 1;
                    k_next = k_reg + CW'(1);
                end
            end
            G_REDUCE: begin
                priority if (u_reg == v_reg) begin
                    u_next = u_reg;
                end else if (!u_reg[0]) begin
                    u_next = u_reg >> 1;
                end else if (!v_reg[0]) begin
                    v_next = v_reg >> 1;
                end else if (u_reg > v_reg) begin
                    u_next = u_reg - v_reg;
                end else begin
                    v_next = v_reg - u_reg;
                end
            end
            G_SCALE: begin
                u_next = u_reg << 1;
                k_next = k_reg - CW'(1);
            end
            G_DONE: begin
                u_next = u_reg;
            end
            default: begin
                u_next = u_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= G_IDLE;
        end else begin
            state_reg <= state_next;
        end
        u_reg <= u_next;
        v_reg <= v_next;
        k_reg <= k_next;
    end

    assign done = (state_reg == G_DONE);
    assign gcd  = u_reg;

endmodule

FILE: test/least_common_multiple_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// least_common_multiple_top_tb
// Self-checking bench for the LCM/GCD block. Operand pairs go in on the input
// stream. Each accepted pair is run through a behavioral GCD/LCM predictor.
// Every returned item is compared field by field with the oldest prediction.
// Directed corner pairs come first. Random pairs with shared factors, powers
// of two and zeros follow. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module least_common_multiple_top_tb;

    import lcm_pkg::*;

    localparam int OPERAND_WIDTH = OPERAND_WIDTH_DEF;
    localparam int CLK_HALF      = 2;     // 4 ns period
    localparam int RESET_CYCLES  = 10;
    // Idle wait after the drain, sized from the worst item inside the block plus a margin.
    localparam int DRAIN_CYCLES  = 7 * OPERAND_WIDTH + 64;
    localparam int STALL_LIMIT   = 4000;
    localparam int REPORT_MAX    = 10;

    typedef struct packed {
        logic [MULT_WIDTH-1:0]  multiple;
        logic [FIELD_WIDTH-1:0] divisor;
        logic                   zero_operand;
    } lcm_result_t;

    typedef struct {
        logic [FIELD_WIDTH-1:0] operand_a;
        logic [FIELD_WIDTH-1:0] operand_b;
        lcm_result_t            result;
    } lcm_pending_t;

    // ---------------------------------------------------------------- DUT I/O
    logic         aclk          = 1'b0;
    logic         aresetn       = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [63:0]  s_axis_tdata  = '0;    // [31:0] operand_a, [63:32] operand_b
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [95:0]  m_axis_tdata;          // [63:0] multiple, [95:64] divisor
    logic         m_axis_tuser;          // [0] zero_operand

    least_common_multiple_top #(
        .OPERAND_WIDTH (OPERAND_WIDTH)
    ) u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // ------------------------------------------------------------ bench state
    lcm_pending_t pending_lcm_q[$];
    int unsigned  pairs_sent     = 0;
    int unsigned  results_seen   = 0;
    int unsigned  zero_results   = 0;
    int unsigned  mismatch_count = 0;
    int unsigned  stray_results  = 0;
    int unsigned  quiet_cycles   = 0;
    bit           tx_idle_on     = 1'b1;   // sender inserts gaps
    bit           rx_stall_on    = 1'b1;   // receiver drops tready

    initial begin
        forever #CLK_HALF aclk = ~aclk;
    end

    // ------------------------------------------------------------- predictor
    // Mask operands to the configured width, Euclid on the masked values,
    // then (a / g) * b as a 64-bit product. A zero operand yields zero fields
    // with the flag set.
    function automatic lcm_result_t predict_lcm(input logic [FIELD_WIDTH-1:0] op_a,
                                                input logic [FIELD_WIDTH-1:0] op_b);
        logic [FIELD_WIDTH-1:0] width_mask;
        logic [FIELD_WIDTH-1:0] x;
        logic [FIELD_WIDTH-1:0] y;
        logic [FIELD_WIDTH-1:0] rem;
        logic [FIELD_WIDTH-1:0] a_m;
        logic [FIELD_WIDTH-1:0] b_m;
        lcm_result_t            r;
        width_mask = FIELD_WIDTH'((64'd1 << OPERAND_WIDTH) - 64'd1);
        a_m = op_a & width_mask;
        b_m = op_b & width_mask;
        r   = '0;
        if (a_m == '0 || b_m == '0) begin
            r.zero_operand = 1'b1;
            return r;
        end
        x = a_m;
        y = b_m;
        while (y != '0) begin
            rem = x % y;
            x   = y;
            y   = rem;
        end
        r.divisor  = x;
        r.multiple = MULT_WIDTH'(a_m / x) * MULT_WIDTH'(b_m);
        return r;
    endfunction

    // Gap length: mostly none, some short, a few long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // Operand with a bias toward the interesting values: zero, all ones,
    // powers of two, small numbers and top-bit-set values.
    function automatic logic [FIELD_WIDTH-1:0] pick_operand();
        int r;
        r = $urandom_range(0, 31);
        if (r == 0) return '0;
        if (r == 1) return '1;
        if (r < 4)  return FIELD_WIDTH'(1) << $urandom_range(0, FIELD_WIDTH - 1);
        if (r < 8)  return FIELD_WIDTH'($urandom_range(1, 255));
        if (r < 10) return $urandom | 32'h8000_0000;
        return $urandom;
    endfunction

    // ------------------------------------------------------------ input side
    // One item per call. tvalid stays high across back-to-back items, so it
    // only gets one assignment per edge.
    task automatic send_operands(input logic [FIELD_WIDTH-1:0] op_a,
                                 input logic [FIELD_WIDTH-1:0] op_b);
        int gap;
        gap = tx_idle_on ? pick_gap() : 0;
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {op_b, op_a};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        pairs_sent++;
    endtask

    // ---------------------------------------------------------- output side
    // Receiver backpressure: per-edge decision, stalls of random length.
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (stall_left != 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else if (rx_stall_on && $urandom_range(0, 99) < 20) begin
                m_axis_tready <= 1'b0;
                stall_left = ($urandom_range(0, 99) < 75) ? $urandom_range(0, 2)
                                                          : $urandom_range(3, 39);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Scoreboard: retire the oldest prediction on each accepted result, then
    // queue a prediction for each accepted operand pair.
    always @(posedge aclk) begin
        lcm_pending_t exp_item;
        lcm_result_t  got;
        if (aresetn) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.multiple     = m_axis_tdata[63:0];
                got.divisor      = m_axis_tdata[95:64];
                got.zero_operand = m_axis_tuser;
                results_seen++;
                if (pending_lcm_q.size() == 0) begin
                    stray_results++;
                    $display("[%0t] result with no pair outstanding: m=%h d=%h z=%b",
                             $realtime, got.multiple, got.divisor, got.zero_operand);
                end else begin
                    exp_item = pending_lcm_q.pop_front();
                    if (exp_item.result.zero_operand) zero_results++;
                    if (got !== exp_item.result) begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_MAX) begin
                            $display("[%0t] mismatch a=%h b=%h", $realtime,
                                     exp_item.operand_a, exp_item.operand_b);
                            $display("    exp m=%h d=%h z=%b got m=%h d=%h z=%b",
                                     exp_item.result.multiple, exp_item.result.divisor,
                                     exp_item.result.zero_operand, got.multiple,
                                     got.divisor, got.zero_operand);
                        end
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                exp_item.operand_a = s_axis_tdata[31:0];
                exp_item.operand_b = s_axis_tdata[63:32];
                exp_item.result    = predict_lcm(s_axis_tdata[31:0], s_axis_tdata[63:32]);
                pending_lcm_q.push_back(exp_item);
            end
        end
    end

    // Watchdog: too long with no handshake on either side means a hang.
    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no handshake for %0d cycles, %0d results outstanding",
                     STALL_LIMIT, pending_lcm_q.size());
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ----------------------------------------------------------------- tests
    // Zero operand in either position, including against the extremes.
    task automatic test_zero_operands();
        send_operands(32'd0, 32'd0);
        send_operands(32'd0, 32'd7);
        send_operands(32'd12, 32'd0);
        send_operands(32'd0, 32'hFFFF_FFFF);
        send_operands(32'hFFFF_FFFF, 32'd0);
    endtask

    // Field extremes, equal operands, divisibility, powers of two, and the
    // largest coprime pair, which puts the multiple near the top of 64 bits.
    task automatic test_extreme_values();
        send_operands(32'd1, 32'd1);
        send_operands(32'd1, 32'hFFFF_FFFF);
        send_operands(32'hFFFF_FFFF, 32'd1);
        send_operands(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_operands(32'hFFFF_FFFF, 32'hFFFF_FFFE);
        send_operands(32'hFFFF_FFFB, 32'hFFFF_FFEF);    // two large primes
        send_operands(32'h8000_0000, 32'h8000_0000);
        send_operands(32'h8000_0000, 32'd3);
        send_operands(32'h8000_0000, 32'h4000_0000);
        send_operands(32'd12, 32'd36);
        send_operands(32'd36, 32'd12);
        send_operands(32'd21, 32'd6);
        send_operands(32'hAAAA_AAAA, 32'h5555_5555);
        send_operands(32'd2, 32'hFFFF_FFFF);
    endtask

    // Independent biased operands; mostly small or tiny common divisors.
    task automatic test_mixed_random(input int count);
        repeat (count) send_operands(pick_operand(), pick_operand());
    endtask

    // Operands built as g*x and g*y, so the divisor is at least g (small, a power
    // of two, or up to 16 bits) and the reduce loop runs through both even and odd stretches.
    task automatic test_shared_factors(input int count);
        logic [FIELD_WIDTH-1:0] g;
        logic [FIELD_WIDTH-1:0] cap;
        int                     r;
        repeat (count) begin
            r = $urandom_range(0, 2);
            if (r == 0)      g = $urandom_range(1, 7);
            else if (r == 1) g = FIELD_WIDTH'(1) << $urandom_range(0, FIELD_WIDTH - 1);
            else             g = $urandom_range(1, 32'hFFFF);
            cap = 32'hFFFF_FFFF / g;
            send_operands(g * $urandom_range(1, cap), g * $urandom_range(1, cap));
        end
    endtask

    // Same mix with both sides always ready: items follow with no gap.
    task automatic test_back_to_back(input int count);
        tx_idle_on  = 1'b0;
        rx_stall_on = 1'b0;
        repeat (count / 2) send_operands(pick_operand(), pick_operand());
        test_shared_factors(count - count / 2);
        tx_idle_on  = 1'b1;
        rx_stall_on = 1'b1;
    endtask

    // ------------------------------------------------------------- sequence
    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        test_zero_operands();
        test_extreme_values();
        test_mixed_random(700);
        test_shared_factors(650);
        test_back_to_back(300);
        s_axis_tvalid <= 1'b0;

        // Drain, then idle a while so that a spurious extra result is caught.
        while (pending_lcm_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d operand pairs (%0d with a zero operand), checked %0d results.",
                 pairs_sent, zero_results, results_seen);
        $display("Mismatches: %0d, unexpected results: %0d.", mismatch_count, stray_results);
        if (mismatch_count == 0 && stray_results == 0 && pending_lcm_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
